>>> design/vtra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Variable table package
// Request and status codes and the result record of the variable table.
// ----------------------------------------------------------------------------
package vtra_pkg;

	typedef enum logic [2:0] {
		REQ_CLEAR    = 3'd0,
		REQ_ENTER    = 3'd1,
		REQ_REF      = 3'd2,
		REQ_FIND_KEY = 3'd3,
		REQ_FIND_REG = 3'd4,
		REQ_FREE_ALL = 3'd5,
		REQ_RESERVE  = 3'd6,
		REQ_NOP      = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOREG    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_ALLOC,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [7:0]  entry_index;
		logic [15:0] occurrences;
		logic [7:0]  first_goal;
		logic [7:0]  last_goal;
		logic [7:0]  last_arg;
		logic [7:0]  temp_reg;
		logic        temp_valid;
		logic        was_referenced;
	} result_t;

	localparam int IN_DATA_BITS  = 72;
	localparam int OUT_DATA_BITS = 64;

endpackage
`default_nettype wire

>>> design/variable_table_with_register_alloc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Variable table with scratch register allocation
// Key-searched table of variable entries plus a scratch register bitmap.
// ----------------------------------------------------------------------------
// One request is taken at a time. Table requests (enter, reference, find key,
// find register) scan the entry memory one slot per cycle from slot 0 through
// its single read port, stopping at a match or after the last filled slot. A
// first reference to a temporary variable then walks the register bitmap one
// register per cycle to the lowest free one, over at most NUM_REGS registers.
// Clear, free, reserve and no-op requests go straight to the response state.
// A finished result sits in the output register while the next request is
// taken. Entries not yet entered since a table clear are never read.
module variable_table_with_register_alloc #(
	parameter int TABLE_DEPTH = 256,
	parameter int NUM_REGS    = 256,
	parameter int KEY_BITS    = 32
) (
	input  wire  logic                                 clk,
	input  wire  logic                                 arst_n,
	input  wire  logic                                 s_tvalid,
	output       logic                                 s_tready,
	// var_key[31:0], goal_num[39:32], arg_num[47:40], is_temp[48],
	// reg_index[56:49], reg_count[65:57]
	input  wire  logic [vtra_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// req_type[2:0]
	input  wire  logic [2:0]                           s_tuser,
	output       logic                                 m_tvalid,
	input  wire  logic                                 m_tready,
	// entry_index[7:0], occurrences[23:8], first_goal[31:24], last_goal[39:32],
	// last_arg[47:40], temp_reg[55:48], temp_valid[56], was_referenced[57]
	output       logic [vtra_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// status[1:0]
	output       logic [1:0]                           m_tuser
);
	import vtra_pkg::*;

	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int TW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = $clog2(NUM_REGS);
	localparam int CW = (RW > 8) ? RW : 8;

	typedef struct packed {
		logic [KW-1:0] key;
		logic [15:0]   cnt;
		logic [7:0]    fgoal;
		logic [7:0]    lgoal;
		logic [7:0]    larg;
		logic [RW-1:0] treg;
		logic          tvalid;
		logic          refd;
	} ent_t;

	ent_t mem [TABLE_DEPTH];

	state_t state_q, state_d;
	req_t   req_q;
	logic [KW-1:0] key_q;
	logic [7:0]    goal_q, arg_q, ridx_q;
	logic          temp_q;
	logic [TW-1:0] total_q, addr_q;
	logic [RW:0]   alloc_q;
	logic [NUM_REGS-1:0] in_use_q;
	logic [SW-1:0] rd_addr_s1, slot_q;
	logic          rd_vld_s1;
	ent_t          rd_data_s1, ent_q;
	result_t       res_q, res_d, out_q;
	status_t       st_q, st_d, out_st_q;
	logic          out_valid_q;

	logic          accept, issue, hit, miss, wr_en, out_free;
	logic          alloc_hit, alloc_end, take_total, set_bit, go_alloc;
	logic [SW-1:0] wr_addr;
	ent_t          wr_data, ne;

	function automatic result_t pack_entry(input logic [SW-1:0] slot, input ent_t e,
			input logic was);
		result_t r;
		logic [SW+7:0] sx;
		logic [CW-1:0] tx;
		sx = {8'd0, slot};
		tx = CW'(e.treg);
		r.entry_index    = sx[7:0];
		r.occurrences    = e.cnt;
		r.first_goal     = e.fgoal;
		r.last_goal      = e.lgoal;
		r.last_arg       = e.larg;
		r.temp_reg       = e.tvalid ? tx[7:0] : 8'd0;
		r.temp_valid     = e.tvalid;
		r.was_referenced = was;
		return r;
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		logic match;
		match = 1'b0;
		if (req_q == REQ_FIND_REG)
			match = rd_data_s1.tvalid && (CW'(rd_data_s1.treg) == CW'(ridx_q));
		else
			match = (rd_data_s1.key == key_q);
		hit   = (state_q == S_SCAN) && rd_vld_s1 && match;
		miss  = (state_q == S_SCAN) && !hit && !rd_vld_s1 && (addr_q >= total_q);
		issue = (state_q == S_SCAN) && !hit && (addr_q < total_q);
		alloc_hit = (state_q == S_ALLOC) && !in_use_q[alloc_q[RW-1:0]];
		alloc_end = (state_q == S_ALLOC) && !alloc_hit &&
			(alloc_q == (RW+1)'(NUM_REGS - 1));
	end

	always_comb begin
		state_d    = state_q;
		res_d      = '0;
		st_d       = ST_OK;
		wr_en      = 1'b0;
		wr_addr    = rd_addr_s1;
		wr_data    = rd_data_s1;
		ne         = rd_data_s1;
		take_total = 1'b0;
		set_bit    = 1'b0;
		go_alloc   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == REQ_ENTER || s_tuser == REQ_REF ||
							s_tuser == REQ_FIND_KEY || s_tuser == REQ_FIND_REG)
						state_d = S_SCAN;
					else
						state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_RESP;
					case (req_q)
						REQ_ENTER: begin
							if (ne.cnt != 16'hFFFF)
								ne.cnt = ne.cnt + 16'd1;
							ne.lgoal = goal_q;
							ne.larg  = arg_q;
							wr_en    = 1'b1;
							wr_data  = ne;
							res_d    = pack_entry(rd_addr_s1, ne, rd_data_s1.refd);
						end
						REQ_REF: begin
							if (rd_data_s1.refd) begin
								res_d = pack_entry(rd_addr_s1, rd_data_s1, 1'b1);
							end else if (temp_q && !rd_data_s1.tvalid) begin
								go_alloc = 1'b1;
								state_d  = S_ALLOC;
							end else begin
								ne.refd = 1'b1;
								wr_en   = 1'b1;
								wr_data = ne;
								res_d   = pack_entry(rd_addr_s1, ne, 1'b0);
							end
						end
						default: res_d = pack_entry(rd_addr_s1, rd_data_s1, rd_data_s1.refd);
					endcase
				end else if (miss) begin
					state_d = S_RESP;
					if (req_q == REQ_ENTER) begin
						if (total_q >= TW'(TABLE_DEPTH)) begin
							st_d = ST_FULL;
						end else begin
							ne.key    = key_q;
							ne.cnt    = 16'd1;
							ne.fgoal  = goal_q;
							ne.lgoal  = goal_q;
							ne.larg   = arg_q;
							ne.treg   = '0;
							ne.tvalid = 1'b0;
							ne.refd   = 1'b0;
							wr_en      = 1'b1;
							wr_addr    = total_q[SW-1:0];
							wr_data    = ne;
							take_total = 1'b1;
							res_d      = pack_entry(total_q[SW-1:0], ne, 1'b0);
						end
					end else begin
						st_d = ST_NOTFOUND;
					end
				end
			end
			S_ALLOC: begin
				ne = ent_q;
				if (alloc_hit) begin
					ne.treg   = alloc_q[RW-1:0];
					ne.tvalid = 1'b1;
					ne.refd   = 1'b1;
					wr_en     = 1'b1;
					wr_addr   = slot_q;
					wr_data   = ne;
					set_bit   = 1'b1;
					res_d     = pack_entry(slot_q, ne, 1'b0);
					state_d   = S_RESP;
				end else if (alloc_end) begin
					st_d    = ST_NOREG;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[addr_q[SW-1:0]];
		rd_addr_s1 <= addr_q[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			in_use_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (accept && s_tuser == REQ_CLEAR)
				total_q <= '0;
			else if (take_total)
				total_q <= total_q + TW'(1);
			if (accept && s_tuser == REQ_FREE_ALL)
				in_use_q <= '0;
			if (accept && s_tuser == REQ_RESERVE) begin
				for (int i = 0; i < NUM_REGS; i++)
					if (i < int'(s_tdata[65:57]))
						in_use_q[i] <= 1'b1;
			end
			if (set_bit)
				in_use_q[alloc_q[RW-1:0]] <= 1'b1;
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_t'(s_tuser);
			key_q  <= s_tdata[KW-1:0];
			goal_q <= s_tdata[39:32];
			arg_q  <= s_tdata[47:40];
			temp_q <= s_tdata[48];
			ridx_q <= s_tdata[56:49];
			addr_q <= '0;
			res_q  <= '0;
			st_q   <= ST_OK;
		end else if (issue) begin
			addr_q <= addr_q + TW'(1);
		end
		if (hit || miss || alloc_hit || alloc_end) begin
			res_q <= res_d;
			st_q  <= st_d;
		end
		if (go_alloc) begin
			ent_q   <= rd_data_s1;
			slot_q  <= rd_addr_s1;
			alloc_q <= '0;
		end else if (state_q == S_ALLOC) begin
			alloc_q <= alloc_q + (RW+1)'(1);
		end
		if (state_q == S_RESP && out_free) begin
			out_q    <= res_q;
			out_st_q <= st_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {6'd0, out_q.was_referenced, out_q.temp_valid, out_q.temp_reg,
		out_q.last_arg, out_q.last_goal, out_q.first_goal, out_q.occurrences,
		out_q.entry_index};

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(TABLE_DEPTH))
		else $error("entry total beyond table depth");
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> addr_q < total_q)
		else $error("scan read beyond filled slots");
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN || state_q == S_ALLOC))
		else $error("entry write outside scan or allocation");
	a_resp_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_free) |=> m_tvalid)
		else $error("result not presented");

endmodule
`default_nettype wire
